[sv/text_console_writer_core_defines.svh]
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcw assertion failed");
`define TCW_ASSERT(lbl, prop) `TCW_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define TCW_ASSERT_CLK(lbl, clk, rst_n, prop)
`define TCW_ASSERT(lbl, prop)
`endif

`endif

[sv/tcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int CELL_COUNT = 4096;
  localparam int CellAw     = $clog2(CELL_COUNT);
  // cursor runs up to 2*64*128 - 128
  localparam int CursorW    = 14;

  localparam logic [15:0] BLANK_CELL   = 16'h0F20;
  localparam logic [15:0] FILL_CELL    = 16'h0020;
  localparam logic [15:0] TEXT_ATTR    = 16'h0F00;
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic CFG_ROWS    = 1'b0;
  localparam logic CFG_COLUMNS = 1'b1;

  localparam logic [6:0] ROWS_MAX    = 7'd64;
  localparam logic [7:0] COLUMNS_MAX = 8'd128;

  typedef struct packed {
    logic        operation;
    logic [7:0]  character;
    logic [11:0] read_address;
  } req_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [11:0] cursor_position;
    logic [11:0] display_start;
  } rsp_t;

endpackage

`default_nettype wire

[sv/text_console_writer_core.sv]
// put item: each cell is written in S_WR and, past the first screen, mirrored in S_MIR;
// a newline walks the rest of its line, and a line start adds the line clear in S_LCLR
// before S_OUT strobes the result. A zero character goes straight to S_OUT.
// read item: one memory read in S_READ. busy drops while the result is strobed, so the
// next item is taken at the edge that ends the strobe; the receiver cannot stall.
// after reset the cell memory is swept to blank, with busy high.
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_writer_core_defines.svh"

module text_console_writer_core
  import tcw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire req_t       req_i,
  output logic            result_valid_o,
  output rsp_t            result_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_MIR   = 3'd4;
  localparam logic [2:0] S_WRAP  = 3'd5;
  localparam logic [2:0] S_LCLR  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [CellAw-1:0]  clr_q, clr_d;
  logic [CursorW-1:0] cursor_q, cursor_d;
  logic [6:0]         col_q, col_d;
  logic [6:0]         line_q, line_d;
  logic [6:0]         cnt_q, cnt_d;
  logic               is_nl_q, is_nl_d;
  logic               rd_ok_q, rd_ok_d;
  logic [15:0]        cell_val_q, cell_val_d;
  logic               res_valid_q, res_valid_d;
  rsp_t               res_q, res_d;
  logic [6:0]         rows_q, rows_d;
  logic [7:0]         cols_q, cols_d;

  logic [6:0]         rows_eff;
  logic [7:0]         cols_eff;
  logic [CursorW-1:0] screen;
  logic [CursorW:0]   wrap_pt;
  logic [7:0]         col_inc;
  logic               col_end;
  logic [7:0]         start_rows;
  logic [15:0]        start_prod;

  logic [15:0]        mem_q [CELL_COUNT];
  logic               mem_req;
  logic               mem_we;
  logic [CursorW-1:0] mem_waddr;
  logic [15:0]        mem_wdata;
  logic [15:0]        rd_data_q;

  // clamp the geometry registers
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = 7'd1;
    end else if (rows_q > ROWS_MAX) begin
      rows_eff = ROWS_MAX;
    end else begin
      rows_eff = rows_q;
    end
    if (cols_q == '0) begin
      cols_eff = 8'd1;
    end else if (cols_q > COLUMNS_MAX) begin
      cols_eff = COLUMNS_MAX;
    end else begin
      cols_eff = cols_q;
    end
  end

  assign screen     = CursorW'(rows_eff) * CursorW'(cols_eff);
  assign wrap_pt    = {screen, 1'b0} - (CursorW + 1)'(cols_eff);
  assign col_inc    = {1'b0, col_q} + 8'd1;
  assign col_end    = (col_inc == cols_eff);
  assign start_rows = {1'b0, line_q} + 8'd1 - {1'b0, rows_eff};
  assign start_prod = 16'(cols_eff) * 16'(start_rows);

  // memory write port
  always_comb begin
    mem_req   = 1'b0;
    mem_waddr = '0;
    mem_wdata = BLANK_CELL;
    case (state_q)
      S_CLEAR: begin
        mem_req   = 1'b1;
        mem_waddr = CursorW'(clr_q);
      end
      S_WR: begin
        mem_req   = 1'b1;
        mem_waddr = cursor_q;
        mem_wdata = cell_val_q;
      end
      S_MIR: begin
        mem_req   = 1'b1;
        mem_waddr = cursor_q - screen;
        mem_wdata = cell_val_q;
      end
      S_LCLR: begin
        mem_req   = 1'b1;
        mem_waddr = cursor_q + CursorW'(cnt_q);
      end
      default: begin
        mem_req = 1'b0;
      end
    endcase
  end

  // cells past the store are dropped
  assign mem_we = mem_req && (32'(mem_waddr) < CELL_COUNT);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[CellAw'(mem_waddr)] <= mem_wdata;
    end
    rd_data_q <= mem_q[CellAw'(req_i.read_address)];
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    line_d      = line_q;
    cnt_d       = cnt_q;
    is_nl_d     = is_nl_q;
    rd_ok_d     = rd_ok_q;
    cell_val_d  = cell_val_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rows_d      = rows_q;
    cols_d      = cols_q;

    case (state_q)
      S_CLEAR: begin
        if (clr_q == CellAw'(CELL_COUNT - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          res_d.cell_data = '0;
          if (req_i.operation == OP_READ) begin
            rd_ok_d = (32'(req_i.read_address) < CELL_COUNT);
            state_d = S_READ;
          end else if (req_i.character == '0) begin
            state_d = S_OUT;
          end else begin
            is_nl_d    = (req_i.character == NEWLINE_CODE);
            cell_val_d = (req_i.character == NEWLINE_CODE) ? FILL_CELL
                                                           : TEXT_ATTR + {8'h00, req_i.character};
            state_d    = S_WR;
          end
        end
      end
      S_READ: begin
        res_d.cell_data = rd_ok_q ? rd_data_q : '0;
        state_d         = S_OUT;
      end
      S_WR, S_MIR: begin
        if (state_q == S_WR && cursor_q >= screen) begin
          state_d = S_MIR;
        end else begin
          cursor_d = cursor_q + 1'b1;
          if (col_end) begin
            col_d  = '0;
            line_d = line_q + 1'b1;
          end else begin
            col_d = col_inc[6:0];
          end
          state_d = (!is_nl_q || col_end) ? S_WRAP : S_WR;
        end
      end
      S_WRAP: begin
        if ({1'b0, cursor_q} == wrap_pt) begin
          cursor_d = cursor_q - screen;
          line_d   = line_q - rows_eff;
        end
        // a fresh line start gets blanked
        if (col_q == '0) begin
          cnt_d   = '0;
          state_d = S_LCLR;
        end else begin
          state_d = S_OUT;
        end
      end
      S_LCLR: begin
        cnt_d = cnt_q + 1'b1;
        if ({1'b0, cnt_q} + 8'd1 == cols_eff) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        res_valid_d           = 1'b1;
        res_d.cursor_position = cursor_q[11:0];
        res_d.display_start   = (cursor_q < screen) ? '0 : start_prod[11:0];
        state_d               = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ROWS) begin
        rows_d = cfg_data_i[6:0];
      end else begin
        cols_d = cfg_data_i;
      end
      cursor_d = '0;
      col_d    = '0;
      line_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      col_q       <= '0;
      line_q      <= '0;
      cnt_q       <= '0;
      is_nl_q     <= 1'b0;
      rd_ok_q     <= 1'b0;
      res_valid_q <= 1'b0;
      rows_q      <= 7'd25;
      cols_q      <= 8'd80;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      line_q      <= line_d;
      cnt_q       <= cnt_d;
      is_nl_q     <= is_nl_d;
      rd_ok_q     <= rd_ok_d;
      res_valid_q <= res_valid_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_val_q <= cell_val_d;
    res_q      <= res_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;
  assign cfg_ready_o    = 1'b1;

  `TCW_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o)
  `TCW_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o)
  `TCW_ASSERT(a_idle_no_write, (state_q == S_IDLE) |-> !mem_we)
  `TCW_ASSERT(a_cursor_bound,
    (state_q == S_IDLE) |-> (({1'b0, cursor_q} < wrap_pt) && ({1'b0, col_q} < cols_eff)))

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  // longest item: newline walk plus line clear at 128 columns
  localparam int DRAIN_CYCLES   = 500;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  req_t       req_i;
  logic       result_valid_o;
  rsp_t       result_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;

  text_console_writer_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // console model state
  logic [15:0] cell_model [CELL_COUNT];
  int unsigned cursor_model;
  logic [6:0]  rows_model;
  logic [7:0]  cols_model;

  rsp_t pending_rsp [$];

  int sender_idle_pct;
  int n_items;
  int n_reads;
  int n_results;
  int n_cfg;
  int n_errors;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic int unsigned active_rows();
    if (rows_model == 7'd0) return 1;
    if (rows_model > ROWS_MAX) return ROWS_MAX;
    return rows_model;
  endfunction

  function automatic int unsigned active_cols();
    if (cols_model == 8'd0) return 1;
    if (cols_model > COLUMNS_MAX) return COLUMNS_MAX;
    return cols_model;
  endfunction

  function automatic void store_cell(int unsigned addr, logic [15:0] v);
    if (addr < CELL_COUNT) cell_model[addr] = v;
  endfunction

  // text and fill cells past the first screen are copied one screen lower
  function automatic void store_mirrored(int unsigned addr, logic [15:0] v, int unsigned scr);
    store_cell(addr, v);
    if (addr >= scr) store_cell(addr - scr, v);
  endfunction

  function automatic rsp_t console_predict(req_t it);
    int unsigned rows;
    int unsigned cols;
    int unsigned scr;
    int unsigned nxt;
    int unsigned c;
    int unsigned start;
    logic [15:0] data;
    rsp_t        r;
    rows = active_rows();
    cols = active_cols();
    scr  = rows * cols;
    data = 16'h0000;
    if (it.operation == OP_READ) begin
      if (it.read_address < CELL_COUNT) data = cell_model[it.read_address];
    end else if (it.character != 8'd0) begin
      if (it.character == NEWLINE_CODE) begin
        nxt = cursor_model - (cursor_model % cols) + cols;
        while (cursor_model != nxt) begin
          store_mirrored(cursor_model, FILL_CELL, scr);
          cursor_model++;
        end
      end else begin
        store_mirrored(cursor_model, TEXT_ATTR + {8'h00, it.character}, scr);
        cursor_model++;
      end
      if (cursor_model == 2 * scr - cols) cursor_model -= scr;
      // every fresh line starts blank
      if (cursor_model % cols == 0) begin
        for (c = cursor_model; c < cursor_model + cols; c++) store_cell(c, BLANK_CELL);
      end
    end
    if (cursor_model < scr) start = 0;
    else start = cols * (cursor_model / cols + 1 - rows);
    r.cell_data       = data;
    r.cursor_position = cursor_model[11:0];
    r.display_start   = start[11:0];
    return r;
  endfunction

  function automatic req_t make_item(logic op, logic [7:0] ch, logic [11:0] addr);
    req_t it;
    it.operation    = op;
    it.character    = ch;
    it.read_address = addr;
    return it;
  endfunction

  function automatic req_t random_item(int nl_pct);
    req_t        it;
    int unsigned span;
    it.character    = 8'($urandom());
    it.read_address = 12'($urandom());
    if ($urandom_range(99) < 35) begin
      it.operation = OP_READ;
      span = 2 * active_rows() * active_cols();
      if (span > CELL_COUNT) span = CELL_COUNT;
      // mostly aim at the region the console actually uses
      if ($urandom_range(3) != 0) it.read_address = 12'($urandom_range(0, span - 1));
    end else begin
      it.operation = OP_PUT;
      if ($urandom_range(99) < nl_pct) it.character = NEWLINE_CODE;
      else if ($urandom_range(49) == 0) it.character = 8'd0;
      else it.character = 8'($urandom_range(1, 255));
    end
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge with start_i still high
  task automatic send_item(req_t it);
    // each cycle the sender holds back with the current idle odds
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_rsp.push_back(console_predict(it));
    n_items++;
    if (it.operation == OP_READ) n_reads++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_rsp.size() != 0 || busy_o);
  endtask

  task automatic write_register(logic idx, logic [7:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_ROWS) rows_model = data[6:0];
    else cols_model = data;
    cursor_model = 0;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no item outstanding: %0h", result_o);
        n_errors++;
      end else begin
        exp_r = pending_rsp.pop_front();
        check_field("cell_data", exp_r.cell_data, result_o.cell_data);
        check_field("cursor_position", {4'h0, exp_r.cursor_position},
                    {4'h0, result_o.cursor_position});
        check_field("display_start", {4'h0, exp_r.display_start},
                    {4'h0, result_o.display_start});
        n_results++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_reset_state();
    send_item(make_item(OP_READ, 8'($urandom()), 12'h000));
    send_item(make_item(OP_READ, 8'($urandom()), 12'hFFF));
    send_item(make_item(OP_PUT, 8'h41, 12'($urandom())));
    send_item(make_item(OP_PUT, 8'hFF, 12'($urandom())));
    // zero character leaves everything alone
    send_item(make_item(OP_PUT, 8'h00, 12'($urandom())));
    send_item(make_item(OP_PUT, NEWLINE_CODE, 12'($urandom())));
    send_item(make_item(OP_READ, 8'($urandom()), 12'h001));
  endtask

  task automatic test_register_limits();
    // zero rows and columns behave as a 1x1 screen
    write_register(CFG_ROWS, 8'h00);
    write_register(CFG_COLUMNS, 8'h00);
    send_item(make_item(OP_PUT, 8'h55, 12'($urandom())));
    send_item(make_item(OP_READ, 8'($urandom()), 12'h000));
    // oversize values clamp to 64x128, larger than the store
    write_register(CFG_ROWS, 8'hFF);
    write_register(CFG_COLUMNS, 8'hFF);
    send_item(make_item(OP_PUT, NEWLINE_CODE, 12'($urandom())));
    send_item(make_item(OP_READ, 8'($urandom()), 12'h000));
  endtask

  task automatic test_mirror_and_wrap();
    // 2x3 screen: mirroring from cell 6, wrap back at cell 9
    write_register(CFG_ROWS, 8'd2);
    write_register(CFG_COLUMNS, 8'd3);
    send_item(make_item(OP_PUT, 8'h61, 12'($urandom())));
    send_item(make_item(OP_PUT, 8'h62, 12'($urandom())));
    send_item(make_item(OP_PUT, NEWLINE_CODE, 12'($urandom())));
    send_item(make_item(OP_PUT, 8'h63, 12'($urandom())));
    send_item(make_item(OP_PUT, 8'h64, 12'($urandom())));
    send_item(make_item(OP_PUT, 8'h01, 12'($urandom())));
    send_item(make_item(OP_PUT, 8'h80, 12'($urandom())));
    send_item(make_item(OP_PUT, NEWLINE_CODE, 12'($urandom())));
    send_item(make_item(OP_READ, 8'($urandom()), 12'h000));
    send_item(make_item(OP_READ, 8'($urandom()), 12'h007));
    send_item(make_item(OP_READ, 8'($urandom()), 12'h003));
  endtask

  task automatic pick_config();
    logic [7:0] rd;
    logic [7:0] cd;
    int         p;
    int         which;
    p = $urandom_range(99);
    if (p < 12) begin
      case ($urandom_range(3))
        0: begin
          rd = 8'd1;
          cd = 8'd1;
        end
        1: begin
          rd = 8'd64;
          cd = 8'd128;
        end
        2: begin
          rd = 8'd0;
          cd = 8'd0;
        end
        default: begin
          rd = 8'hFF;
          cd = 8'hFF;
        end
      endcase
    end else if (p < 80) begin
      // small screens wrap often
      rd    = 8'($urandom_range(1, 6));
      rd[7] = 1'($urandom_range(1));
      cd    = 8'($urandom_range(1, 16));
    end else begin
      rd = 8'($urandom());
      cd = 8'($urandom());
    end
    which = $urandom_range(2);
    if (which != 2) write_register(CFG_ROWS, rd);
    if (which != 1) write_register(CFG_COLUMNS, cd);
  endtask

  task automatic test_random_traffic(int count, int idle_pct);
    int sent;
    int seg;
    int nl_pct;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < count) begin
      pick_config();
      seg    = $urandom_range(15, 50);
      nl_pct = $urandom_range(3, 40);
      repeat (seg) begin
        send_item(random_item(nl_pct));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    req_i           = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_ROWS;
    cfg_data_i      = 8'h00;
    sender_idle_pct = 0;
    n_items         = 0;
    n_reads         = 0;
    n_results       = 0;
    n_cfg           = 0;
    n_errors        = 0;
    stall_cycles    = 0;
    for (int i = 0; i < CELL_COUNT; i++) cell_model[i] = BLANK_CELL;
    cursor_model = 0;
    rows_model   = 7'd25;
    cols_model   = 8'd80;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    sender_idle_pct = 30;
    test_reset_state();
    test_register_limits();
    test_mirror_and_wrap();
    test_random_traffic(200, 30);
    test_random_traffic(200, 51);
    test_random_traffic(200, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $error("%0d results never arrived", pending_rsp.size());
      n_errors++;
    end
    $display("%0d items sent (%0d reads), %0d results checked, %0d register writes",
             n_items, n_reads, n_results, n_cfg);
    $display("screens from 1x1 to clamped 64x128, sender gaps light, heavy and none");
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
